// ===== sv/i2c_sensor_transaction_sequencer_top_macros.svh =====
// Assertion macros shared by the I2C sensor sequencer modules.
// Needs no other file; included by the modules that carry assertions.
`ifndef I2C_SENSOR_TRANSACTION_SEQUENCER_TOP_MACROS_SVH
`define I2C_SENSOR_TRANSACTION_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define I2CSEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define I2CSEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/i2cseq_pkg.sv =====
// Types, codes and helpers of the I2C sensor transaction sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2cseq_pkg;

   // Bus event codes.
   localparam logic [2:0] ACT_START  = 3'd0;
   localparam logic [2:0] ACT_ACK    = 3'd1;
   localparam logic [2:0] ACT_NACK   = 3'd2;
   localparam logic [2:0] ACT_RXBYTE = 3'd3;
   localparam logic [2:0] ACT_MSTOP  = 3'd4;

   // Bus command bits.
   localparam logic [4:0] CM_START = 5'b00001;
   localparam logic [4:0] CM_STOP  = 5'b00010;
   localparam logic [4:0] CM_ACK   = 5'b00100;
   localparam logic [4:0] CM_NACK  = 5'b01000;
   localparam logic [4:0] CM_CONT  = 5'b10000;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SLAVE_ADDRESS  = 3'd0;
   localparam logic [2:0] CSR_READ_MODE      = 3'd1;
   localparam logic [2:0] CSR_COMMAND_WORD   = 3'd2;
   localparam logic [2:0] CSR_COMMAND_LENGTH = 3'd3;
   localparam logic [2:0] CSR_RECEIVE_COUNT  = 3'd4;
   localparam logic [2:0] CSR_CHECK_ENABLE   = 3'd5;
   localparam logic [2:0] CSR_KEEP_BUS       = 3'd6;
   localparam logic [2:0] CSR_WRITE_BYTE     = 3'd7;

   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam logic [2:0] RX_COUNT_RESET = 3'd6;

   // Phase codes as reported on the result word.
   localparam logic [2:0] PC_IDLE = 3'd0;
   localparam logic [2:0] PC_REQ  = 3'd1;
   localparam logic [2:0] PC_CMD  = 3'd2;
   localparam logic [2:0] PC_DREQ = 3'd3;
   localparam logic [2:0] PC_DATA = 3'd4;
   localparam logic [2:0] PC_STOP = 3'd5;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_REQ  = 6'b000010,
      PH_CMD  = 6'b000100,
      PH_DREQ = 6'b001000,
      PH_DATA = 6'b010000,
      PH_STOP = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]  cmd_mask;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [31:0] measurement;
      logic [15:0] check_bytes;
      logic        busy_res;
      logic        done_res;
      logic        bus_reset;
      logic        logic_error;
      logic [2:0]  phase_now;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  slave_address;
      logic        read_mode;
      logic [15:0] command_word;
      logic [1:0]  command_length;
      logic [2:0]  receive_count;
      logic        check_enable;
      logic        keep_bus;
      logic [7:0]  write_byte;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  cmd_left;
      logic [2:0]  rx_left;
      logic [15:0] pend_cmd;
      logic [7:0]  pend_write;
      logic [31:0] meas;
      logic [15:0] check;
      logic        busy;
   } state_type;

   function automatic logic [7:0] header_byte(input logic [6:0] addr, input logic rw);
      return {addr, rw};
   endfunction

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      unique case (ph)
         PH_IDLE: code = PC_IDLE;
         PH_REQ:  code = PC_REQ;
         PH_CMD:  code = PC_CMD;
         PH_DREQ: code = PC_DREQ;
         PH_DATA: code = PC_DATA;
         PH_STOP: code = PC_STOP;
         default: code = PC_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/i2cseq_core.sv =====
// Next-state and result logic for one bus event of the I2C sensor sequencer.
// Purely combinational; depends on i2cseq_pkg.
`timescale 1ns / 1ps

module i2cseq_core (
   input  i2cseq_pkg::state_type st,
   input  i2cseq_pkg::cfg_type   cfg,
   input  i2cseq_pkg::req_type   req,
   output i2cseq_pkg::state_type nxt,
   output i2cseq_pkg::rsp_type   rsp
);
   import i2cseq_pkg::*;

   state_type  upd;
   logic [4:0] cmd;
   logic       txv;
   logic [7:0] txb;
   logic       done;
   logic       breset;
   logic       err;
   logic [2:0] left_dec;

   assign left_dec = st.rx_left - 3'd1;

   always_comb begin
      upd    = st;
      cmd    = '0;
      txv    = 1'b0;
      txb    = '0;
      done   = 1'b0;
      breset = 1'b0;
      err    = 1'b0;
      unique case (req.action)
         ACT_START: begin
            if (st.busy) begin
               err = 1'b1;
            end else begin
               upd.cmd_left   = cfg.command_length;
               upd.rx_left    = cfg.receive_count;
               upd.pend_cmd   = cfg.command_word;
               upd.pend_write = cfg.write_byte;
               upd.meas       = '0;
               upd.check      = '0;
               upd.busy       = 1'b1;
               upd.phase      = PH_REQ;
               cmd            = CM_START;
               txv            = 1'b1;
               txb            = header_byte(cfg.slave_address,
                                            cfg.read_mode && (cfg.command_length == 2'd0));
            end
         end
         ACT_ACK: begin
            unique case (st.phase)
               PH_REQ: begin
                  if (st.cmd_left == 2'd0) begin
                     if (cfg.read_mode) begin
                        upd.phase = PH_DATA;
                     end else begin
                        err = 1'b1;
                     end
                  end else if (st.cmd_left == 2'd1) begin
                     txv       = 1'b1;
                     txb       = st.pend_cmd[7:0];
                     upd.phase = PH_CMD;
                  end else if (st.cmd_left == 2'd2 && !cfg.read_mode) begin
                     // MSB goes out now; the LSB becomes both the resend and the next byte.
                     txv            = 1'b1;
                     txb            = st.pend_cmd[15:8];
                     upd.cmd_left   = 2'd1;
                     upd.pend_cmd   = {8'h00, st.pend_cmd[7:0]};
                     upd.pend_write = st.pend_cmd[7:0];
                     upd.phase      = PH_CMD;
                  end else begin
                     err = 1'b1;
                  end
               end
               PH_CMD: begin
                  txv = 1'b1;
                  if (cfg.read_mode) begin
                     cmd       = CM_START;
                     txb       = header_byte(cfg.slave_address, 1'b1);
                     upd.phase = PH_DREQ;
                  end else begin
                     txb       = st.pend_write;
                     upd.phase = PH_DATA;
                  end
               end
               PH_DREQ: upd.phase = PH_DATA;
               PH_DATA: begin
                  if (!cfg.read_mode) begin
                     cmd       = CM_STOP;
                     upd.phase = PH_STOP;
                  end else begin
                     err = 1'b1;
                  end
               end
               default: err = 1'b1;
            endcase
         end
         ACT_NACK: begin
            unique case (st.phase)
               PH_REQ: begin
                  if (st.rx_left > 3'd3) begin
                     cmd       = CM_STOP;
                     upd.phase = PH_STOP;
                  end else begin
                     cmd = CM_START;
                     txv = 1'b1;
                     txb = header_byte(cfg.slave_address, 1'b0);
                  end
               end
               PH_CMD: begin
                  cmd = CM_CONT;
                  txv = 1'b1;
                  txb = st.pend_cmd[7:0];
               end
               PH_DREQ: begin
                  if (cfg.read_mode) begin
                     cmd = CM_START;
                     txv = 1'b1;
                     txb = header_byte(cfg.slave_address, 1'b1);
                  end else if (st.rx_left == 3'd2) begin
                     upd.phase = PH_CMD;
                  end else begin
                     cmd = CM_START;
                     txv = 1'b1;
                     txb = header_byte(cfg.slave_address, 1'b0);
                  end
               end
               default: err = 1'b1;
            endcase
         end
         ACT_RXBYTE: begin
            if (st.phase != PH_DATA || !cfg.read_mode || st.rx_left == 3'd0) begin
               err = 1'b1;
            end else begin
               // Bytes at counts one, four and seven are check bytes.
               case (st.rx_left) inside
                  3'd1, 3'd7: begin
                     if (cfg.check_enable) upd.check = st.check | {8'h00, req.rx_byte};
                  end
                  3'd4: begin
                     if (cfg.check_enable) upd.check = st.check | {req.rx_byte, 8'h00};
                  end
                  3'd6:    upd.meas = st.meas | {req.rx_byte, 24'h000000};
                  3'd5:    upd.meas = st.meas | {8'h00, req.rx_byte, 16'h0000};
                  3'd3:    upd.meas = st.meas | {16'h0000, req.rx_byte, 8'h00};
                  default: upd.meas = st.meas | {24'h000000, req.rx_byte};
               endcase
               upd.rx_left = left_dec;
               if ((cfg.check_enable && left_dec == 3'd0) ||
                   (!cfg.check_enable && left_dec == 3'd1)) begin
                  cmd       = CM_NACK | CM_STOP;
                  upd.phase = PH_STOP;
               end else begin
                  cmd = CM_ACK;
               end
            end
         end
         ACT_MSTOP: begin
            if (st.phase != PH_STOP) begin
               err = 1'b1;
            end else begin
               breset    = !cfg.keep_bus;
               upd.busy  = 1'b0;
               done      = 1'b1;
               upd.phase = PH_IDLE;
            end
         end
         default: err = 1'b1;
      endcase
   end

   // An unexpected event leaves every state element as it was.
   assign nxt = err ? st : upd;

   always_comb begin
      rsp.cmd_mask    = cmd;
      rsp.tx_valid    = txv;
      rsp.tx_byte     = txv ? txb : 8'h00;
      rsp.measurement = nxt.meas;
      rsp.check_bytes = nxt.check;
      rsp.busy_res    = nxt.busy;
      rsp.done_res    = done;
      rsp.bus_reset   = breset;
      rsp.logic_error = err;
      rsp.phase_now   = phase_code(nxt.phase);
   end

endmodule

// ===== sv/i2cseq_rsp_buf.sv =====
// Two-entry result buffer (output register plus skid register) for the sequencer.
// Depends on i2cseq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_sensor_transaction_sequencer_top_macros.svh"

module i2cseq_rsp_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  i2cseq_pkg::rsp_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output i2cseq_pkg::rsp_type out_data
);
   import i2cseq_pkg::*;

   logic    out_vld_ff;
   logic    out_vld_in;
   rsp_type out_data_ff;
   logic    skid_vld_ff;
   logic    skid_vld_in;
   rsp_type skid_data_ff;
   logic    in_take;
   logic    out_free;

   assign in_ready  = !skid_vld_ff;
   assign in_take   = in_valid && in_ready;
   assign out_free  = !out_vld_ff || out_ready;
   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (out_free) begin
         // The skid word, when present, is older than anything new.
         out_vld_in  = skid_vld_ff || in_take;
         skid_vld_in = 1'b0;
      end else if (in_take) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : in_data;
      end else if (in_take) begin
         skid_data_ff <= in_data;
      end
   end

   `I2CSEQ_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_vld_ff, out_vld_ff, "skid word without output word")
   `I2CSEQ_ASSERT_NEXT(a_skid_drains, clock, reset, skid_vld_ff && out_ready, out_vld_ff && !skid_vld_ff, "skid word not moved forward")
   `I2CSEQ_ASSERT_NEXT(a_stall_fills_skid, clock, reset, in_take && out_vld_ff && !out_ready, skid_vld_ff, "accepted word lost during stall")

endmodule

// ===== sv/i2c_sensor_transaction_sequencer_top.sv =====
// Top level of the I2C sensor transaction sequencer: registers, event logic, result buffer.
// Depends on i2cseq_pkg, i2cseq_core, i2cseq_rsp_buf and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_sensor_transaction_sequencer_top_macros.svh"

// The sequencer takes one bus event word per clock while req_ready is high and returns
// exactly one result word for it: the bus commands, an optional transmit byte and a snapshot
// of the measurement, check bytes, busy flag and phase. The phase logic is combinational
// from the state registers and the event; the result is registered in the output register,
// or in the skid register while the output stalls. A two-word result buffer keeps req_ready
// high while one finished result waits on rsp_ready; only a second stalled result drops
// req_ready. Configuration registers are written through csr_we/csr_index/csr_wdata and
// must only be changed while no transaction result is outstanding.
module i2c_sensor_transaction_sequencer_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cseq_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cseq_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import i2cseq_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   rsp_type   core_rsp;
   logic      req_take;

   assign req_take = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:  cfg_in.slave_address  = csr_wdata[6:0];
            CSR_READ_MODE:      cfg_in.read_mode      = csr_wdata[0];
            CSR_COMMAND_WORD:   cfg_in.command_word   = csr_wdata[CSR_DATA_WIDTH-1:0];
            CSR_COMMAND_LENGTH: cfg_in.command_length = csr_wdata[1:0];
            CSR_RECEIVE_COUNT:  cfg_in.receive_count  = csr_wdata[2:0];
            CSR_CHECK_ENABLE:   cfg_in.check_enable   = csr_wdata[0];
            CSR_KEEP_BUS:       cfg_in.keep_bus       = csr_wdata[0];
            CSR_WRITE_BYTE:     cfg_in.write_byte     = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address  <= '0;
         cfg_ff.read_mode      <= 1'b0;
         cfg_ff.command_word   <= '0;
         cfg_ff.command_length <= '0;
         cfg_ff.receive_count  <= RX_COUNT_RESET;
         cfg_ff.check_enable   <= 1'b0;
         cfg_ff.keep_bus       <= 1'b0;
         cfg_ff.write_byte     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cseq_core u_core (
      .st  (state_ff),
      .cfg (cfg_ff),
      .req (req_data),
      .nxt (state_in),
      .rsp (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.cmd_left   <= '0;
         state_ff.rx_left    <= '0;
         state_ff.pend_cmd   <= '0;
         state_ff.pend_write <= '0;
         state_ff.meas       <= '0;
         state_ff.check      <= '0;
         state_ff.busy       <= 1'b0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   i2cseq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (core_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   `I2CSEQ_ASSERT_NOW(a_phase_onehot, clock, reset, 1'b1, $onehot(state_ff.phase), "phase register not one-hot")
   `I2CSEQ_ASSERT_NOW(a_busy_matches_phase, clock, reset, 1'b1, state_ff.busy == (state_ff.phase != PH_IDLE), "busy flag disagrees with phase")
   `I2CSEQ_ASSERT_NEXT(a_error_holds_state, clock, reset, req_take && core_rsp.logic_error, $stable(state_ff), "unexpected event changed state")
   `I2CSEQ_ASSERT_NOW(a_done_from_stop, clock, reset, req_take && core_rsp.done_res, state_ff.phase == PH_STOP, "transaction ended outside stopping phase")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the I2C sensor transaction sequencer top level.
// Depends on i2cseq_pkg and i2c_sensor_transaction_sequencer_top; predicts every result word
// from its own model of the phase logic and compares it against the block's output.
`timescale 1ns / 1ps

module testbench;
   import i2cseq_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SHOWN_MISMATCHES = 10;
   localparam int unsigned SETTLE_CYCLES = 20;

   // Event codes that the block does not define.
   localparam logic [2:0] ACT_SPARE_A = 3'd5;
   localparam logic [2:0] ACT_SPARE_B = 3'd6;
   localparam logic [2:0] ACT_SPARE_C = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   i2c_sensor_transaction_sequencer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the sequencer state and of its registers.
   cfg_type     setup;
   logic [2:0]  seq_phase;
   logic [1:0]  cmd_bytes_due;
   logic [2:0]  rx_bytes_due;
   logic [15:0] cmd_held;
   logic [7:0]  data_held;
   logic [31:0] meas_acc;
   logic [15:0] check_acc;
   logic        seq_busy;

   rsp_type     bus_answers_due[$];
   int unsigned mismatches = 0;
   int unsigned useful_events = 0;
   int unsigned stall_request = 0;
   logic        gaps_on = 1'b1;
   logic        setup_stale = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the result word for one bus event and advances the mirror state.
   function automatic rsp_type sequence_event(input req_type ev);
      rsp_type ans;
      logic    rw;
      ans = '0;
      case (ev.action)
         ACT_START: begin
            if (seq_busy) begin
               ans.logic_error = 1'b1;
            end else begin
               cmd_bytes_due = setup.command_length;
               rx_bytes_due = setup.receive_count;
               cmd_held = setup.command_word;
               data_held = setup.write_byte;
               meas_acc = '0;
               check_acc = '0;
               seq_busy = 1'b1;
               seq_phase = PC_REQ;
               rw = setup.read_mode && setup.command_length == 2'd0;
               ans.cmd_mask = CM_START;
               ans.tx_valid = 1'b1;
               ans.tx_byte = {setup.slave_address, rw};
            end
         end
         ACT_ACK: begin
            if (seq_phase == PC_REQ) begin
               if (cmd_bytes_due == 2'd0) begin
                  if (setup.read_mode) seq_phase = PC_DATA;
                  else ans.logic_error = 1'b1;
               end else if (cmd_bytes_due == 2'd1) begin
                  ans.tx_valid = 1'b1;
                  ans.tx_byte = cmd_held[7:0];
                  seq_phase = PC_CMD;
               end else if (cmd_bytes_due == 2'd2 && !setup.read_mode) begin
                  // The high byte goes out now; the low byte is both resent and written next.
                  ans.tx_valid = 1'b1;
                  ans.tx_byte = cmd_held[15:8];
                  cmd_bytes_due = 2'd1;
                  cmd_held = {8'h00, cmd_held[7:0]};
                  data_held = cmd_held[7:0];
                  seq_phase = PC_CMD;
               end else begin
                  ans.logic_error = 1'b1;
               end
            end else if (seq_phase == PC_CMD) begin
               ans.tx_valid = 1'b1;
               if (setup.read_mode) begin
                  ans.cmd_mask = CM_START;
                  ans.tx_byte = {setup.slave_address, 1'b1};
                  seq_phase = PC_DREQ;
               end else begin
                  ans.tx_byte = data_held;
                  seq_phase = PC_DATA;
               end
            end else if (seq_phase == PC_DREQ) begin
               seq_phase = PC_DATA;
            end else if (seq_phase == PC_DATA && !setup.read_mode) begin
               ans.cmd_mask = CM_STOP;
               seq_phase = PC_STOP;
            end else begin
               ans.logic_error = 1'b1;
            end
         end
         ACT_NACK: begin
            if (seq_phase == PC_REQ) begin
               if (rx_bytes_due > 3'd3) begin
                  ans.cmd_mask = CM_STOP;
                  seq_phase = PC_STOP;
               end else begin
                  ans.cmd_mask = CM_START;
                  ans.tx_valid = 1'b1;
                  ans.tx_byte = {setup.slave_address, 1'b0};
               end
            end else if (seq_phase == PC_CMD) begin
               ans.cmd_mask = CM_CONT;
               ans.tx_valid = 1'b1;
               ans.tx_byte = cmd_held[7:0];
            end else if (seq_phase == PC_DREQ) begin
               if (setup.read_mode) begin
                  ans.cmd_mask = CM_START;
                  ans.tx_valid = 1'b1;
                  ans.tx_byte = {setup.slave_address, 1'b1};
               end else if (rx_bytes_due == 3'd2) begin
                  seq_phase = PC_CMD;
               end else begin
                  ans.cmd_mask = CM_START;
                  ans.tx_valid = 1'b1;
                  ans.tx_byte = {setup.slave_address, 1'b0};
               end
            end else begin
               ans.logic_error = 1'b1;
            end
         end
         ACT_RXBYTE: begin
            if (seq_phase != PC_DATA || !setup.read_mode || rx_bytes_due == 3'd0) begin
               ans.logic_error = 1'b1;
            end else begin
               // Bytes at counts 1, 4 and 7 are check bytes; the rest fill the measurement.
               case (rx_bytes_due)
                  3'd6: meas_acc[31:24] = meas_acc[31:24] | ev.rx_byte;
                  3'd5: meas_acc[23:16] = meas_acc[23:16] | ev.rx_byte;
                  3'd3: meas_acc[15:8] = meas_acc[15:8] | ev.rx_byte;
                  3'd2: meas_acc[7:0] = meas_acc[7:0] | ev.rx_byte;
                  3'd4: if (setup.check_enable) check_acc[15:8] = check_acc[15:8] | ev.rx_byte;
                  default: if (setup.check_enable) check_acc[7:0] = check_acc[7:0] | ev.rx_byte;
               endcase
               rx_bytes_due = rx_bytes_due - 3'd1;
               if ((setup.check_enable && rx_bytes_due == 3'd0) ||
                   (!setup.check_enable && rx_bytes_due == 3'd1)) begin
                  ans.cmd_mask = CM_NACK | CM_STOP;
                  seq_phase = PC_STOP;
               end else begin
                  ans.cmd_mask = CM_ACK;
               end
            end
         end
         ACT_MSTOP: begin
            if (seq_phase != PC_STOP) begin
               ans.logic_error = 1'b1;
            end else begin
               ans.bus_reset = !setup.keep_bus;
               ans.done_res = 1'b1;
               seq_busy = 1'b0;
               seq_phase = PC_IDLE;
            end
         end
         default: ans.logic_error = 1'b1;
      endcase
      ans.measurement = meas_acc;
      ans.check_bytes = check_acc;
      ans.busy_res = seq_busy;
      ans.phase_now = seq_phase;
      return ans;
   endfunction

   function automatic string answer_text(input rsp_type a);
      return $sformatf("cmd=%h tx=%b/%h meas=%h chk=%h busy=%b done=%b brst=%b err=%b ph=%0d",
                       a.cmd_mask, a.tx_valid, a.tx_byte, a.measurement, a.check_bytes,
                       a.busy_res, a.done_res, a.bus_reset, a.logic_error, a.phase_now);
   endfunction

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Only settings from which every transaction can still reach the stop phase.
   function automatic cfg_type random_setup();
      cfg_type c;
      logic    req_ok;
      logic    data_ok;
      do begin
         c.slave_address = ($urandom_range(0, 5) == 0) ? 7'h7F : 7'($urandom_range(0, 127));
         c.read_mode = 1'($urandom_range(0, 1));
         c.command_word = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         c.command_length = 2'($urandom_range(0, 3));
         c.receive_count = 3'($urandom_range(0, 7));
         c.check_enable = 1'($urandom_range(0, 1));
         c.keep_bus = 1'($urandom_range(0, 1));
         c.write_byte = random_byte();
         req_ok = c.receive_count > 3'd3 ||
                  (c.read_mode ? c.command_length <= 2'd1 :
                   (c.command_length == 2'd1 || c.command_length == 2'd2));
         data_ok = !c.read_mode || c.receive_count >= 3'd2 ||
                   (c.receive_count == 3'd1 && c.check_enable);
      end while (!(req_ok && data_ok));
      return c;
   endfunction

   // Mostly well-formed traffic for the current phase, with some stray events.
   function automatic req_type next_bus_event();
      req_type ev;
      logic    ack_refused;
      ev.rx_byte = random_byte();
      ev.action = ACT_START;
      ack_refused = (cmd_bytes_due == 2'd0 && !setup.read_mode) ||
                    (cmd_bytes_due == 2'd2 && setup.read_mode) || cmd_bytes_due == 2'd3;
      if ($urandom_range(0, 99) < 6) begin
         ev.action = 3'($urandom_range(0, 7));
      end else begin
         case (seq_phase)
            PC_IDLE: ev.action = ACT_START;
            PC_REQ: begin
               if (ack_refused || $urandom_range(0, 6) == 0) ev.action = ACT_NACK;
               else ev.action = ACT_ACK;
            end
            PC_CMD, PC_DREQ: ev.action = ($urandom_range(0, 4) == 0) ? ACT_NACK : ACT_ACK;
            PC_DATA: ev.action = setup.read_mode ? ACT_RXBYTE : ACT_ACK;
            default: ev.action = ACT_MSTOP;
         endcase
      end
      return ev;
   endfunction

   task automatic send_bus_event(input req_type ev);
      int unsigned gap;
      rsp_type     answer;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      answer = sequence_event(ev);
      bus_answers_due.push_back(answer);
      if (!answer.logic_error) useful_events++;
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (bus_answers_due.size() != 0) @(posedge clock);
   endtask

   // Writes all eight registers, one per cycle; call only with nothing outstanding.
   task automatic load_setup(input cfg_type c);
      logic [15:0] value [8];
      value[CSR_SLAVE_ADDRESS] = 16'(c.slave_address);
      value[CSR_READ_MODE] = 16'(c.read_mode);
      value[CSR_COMMAND_WORD] = c.command_word;
      value[CSR_COMMAND_LENGTH] = 16'(c.command_length);
      value[CSR_RECEIVE_COUNT] = 16'(c.receive_count);
      value[CSR_CHECK_ENABLE] = 16'(c.check_enable);
      value[CSR_KEEP_BUS] = 16'(c.keep_bus);
      value[CSR_WRITE_BYTE] = 16'(c.write_byte);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      setup = c;
   endtask

   // Field order: address, read, command, command length, receive count, check, keep bus,
   // write byte.
   task automatic check_write_transfer();
      wait_for_answers();
      load_setup('{7'h7F, 1'b0, 16'hFFFF, 2'd2, 3'd6, 1'b0, 1'b0, 8'h00});
      send_bus_event('{ACT_START, 8'h00});
      send_bus_event('{ACT_START, 8'hFF});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_NACK, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_MSTOP, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_MSTOP, 8'h00});
   endtask

   task automatic check_read_transfer();
      logic [7:0] rx_seq [7] = '{8'hFF, 8'h00, 8'hA5, 8'hFF, 8'h5A, 8'h00, 8'hFF};
      wait_for_answers();
      load_setup('{7'h00, 1'b1, 16'h0000, 2'd0, 3'd7, 1'b1, 1'b1, 8'hFF});
      send_bus_event('{ACT_START, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      foreach (rx_seq[i]) send_bus_event('{ACT_RXBYTE, rx_seq[i]});
      send_bus_event('{ACT_MSTOP, 8'h00});
   endtask

   task automatic check_nack_recovery();
      wait_for_answers();
      load_setup('{7'h55, 1'b1, 16'h1234, 2'd1, 3'd2, 1'b0, 1'b0, 8'h3C});
      send_bus_event('{ACT_START, 8'h00});
      send_bus_event('{ACT_NACK, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_NACK, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_NACK, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_RXBYTE, 8'h81});
      send_bus_event('{ACT_MSTOP, 8'h00});
   endtask

   // Spare codes and stray events while idle, then a request that no ack can satisfy.
   task automatic check_protocol_errors();
      wait_for_answers();
      load_setup('{7'h2A, 1'b0, 16'hBEEF, 2'd3, 3'd6, 1'b0, 1'b1, 8'h11});
      send_bus_event('{ACT_SPARE_A, 8'hFF});
      send_bus_event('{ACT_SPARE_B, 8'h00});
      send_bus_event('{ACT_SPARE_C, 8'hFF});
      send_bus_event('{ACT_RXBYTE, 8'h77});
      send_bus_event('{ACT_START, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_NACK, 8'h00});
      send_bus_event('{ACT_MSTOP, 8'h00});
   endtask

   // Runs until the given number of error-free events has been taken and the bus is idle again.
   task automatic run_random_traffic(input int unsigned n_events);
      int unsigned target;
      cfg_type     flipped;
      target = useful_events + n_events;
      while (useful_events < target || seq_phase != PC_IDLE) begin
         if (seq_phase == PC_IDLE && (setup_stale || $urandom_range(0, 3) == 0)) begin
            wait_for_answers();
            load_setup(random_setup());
            setup_stale = 1'b0;
         end else if (seq_phase == PC_DREQ && setup.read_mode && $urandom_range(0, 5) == 0) begin
            // Switching to write mode here exercises the write side of the data request.
            wait_for_answers();
            flipped = setup;
            flipped.read_mode = 1'b0;
            load_setup(flipped);
            setup_stale = 1'b1;
         end
         send_bus_event(next_bus_event());
      end
   endtask

   task automatic check_output_stall();
      gaps_on = 1'b0;
      wait_for_answers();
      stall_request = 90;
      run_random_traffic(40);
      wait_for_answers();
      gaps_on = 1'b1;
   endtask

   // A read with nothing to receive leaves the sequencer stuck, so this runs last.
   task automatic check_exhausted_read();
      wait_for_answers();
      load_setup('{7'h01, 1'b1, 16'h0001, 2'd0, 3'd0, 1'b0, 1'b0, 8'h01});
      send_bus_event('{ACT_START, 8'h00});
      send_bus_event('{ACT_ACK, 8'h00});
      send_bus_event('{ACT_RXBYTE, 8'hFF});
      send_bus_event('{ACT_NACK, 8'h00});
      send_bus_event('{ACT_RXBYTE, 8'h00});
   endtask

   initial begin : receiver
      int unsigned burst;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request != 0) begin
            burst = stall_request;
            stall_request = 0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 13);
         end else begin
            burst = 0;
         end
         if (burst != 0) begin
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bus_answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
               $display("unexpected result word: %s", answer_text(rsp_data));
         end else begin
            due = bus_answers_due.pop_front();
            if (rsp_data.cmd_mask !== due.cmd_mask || rsp_data.tx_valid !== due.tx_valid ||
                rsp_data.tx_byte !== due.tx_byte || rsp_data.measurement !== due.measurement ||
                rsp_data.check_bytes !== due.check_bytes ||
                rsp_data.busy_res !== due.busy_res || rsp_data.done_res !== due.done_res ||
                rsp_data.bus_reset !== due.bus_reset ||
                rsp_data.logic_error !== due.logic_error ||
                rsp_data.phase_now !== due.phase_now) begin
               mismatches++;
               if (mismatches <= SHOWN_MISMATCHES) begin
                  $display("mismatch: expected %s", answer_text(due));
                  $display("          actual   %s", answer_text(rsp_data));
               end
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_SLAVE_ADDRESS;
      csr_wdata <= '0;
      setup = '{7'h00, 1'b0, 16'h0000, 2'd0, RX_COUNT_RESET, 1'b0, 1'b0, 8'h00};
      seq_phase = PC_IDLE;
      cmd_bytes_due = '0;
      rx_bytes_due = '0;
      cmd_held = '0;
      data_held = '0;
      meas_acc = '0;
      check_acc = '0;
      seq_busy = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      check_write_transfer();
      check_read_transfer();
      check_nack_recovery();
      check_protocol_errors();
      run_random_traffic(900);
      check_output_stall();
      gaps_on = 1'b0;
      run_random_traffic(600);
      check_exhausted_read();

      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && bus_answers_due.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/i2cseq_pkg.sv
sv/i2cseq_core.sv
sv/i2cseq_rsp_buf.sv
sv/i2c_sensor_transaction_sequencer_top.sv
test/testbench.sv
